>>> sv/ssme_pkg.sv
// shared constants, codes and the result record of the sorted set merge engine
// no dependencies; every other file refers to this package by scoped name
package ssme_pkg;

	localparam int SET_DEPTH_DEFAULT = 16;

	localparam int FUNC_W  = 3;
	localparam int VALUE_W = 24;
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 6;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNION    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DIFF     = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_INTER    = 3'd5;

	localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] element;
		logic [COUNT_W-1:0] result_count;
		logic               status;
		logic               last;
	} result_t;

endpackage

>>> sv/ssme_if.sv
// valid/ready channel interfaces for command items and result items
// depends on ssme_pkg for field widths
interface ssme_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [ssme_pkg::FUNC_W-1:0]  func;
	logic [ssme_pkg::VALUE_W-1:0] node_value;

	modport source (output valid, func, node_value, input ready);
	modport sink (input valid, func, node_value, output ready);
endinterface

interface ssme_res_if;
	logic                         valid;
	logic                         ready;
	logic [ssme_pkg::KIND_W-1:0]  kind;
	logic [ssme_pkg::VALUE_W-1:0] element;
	logic [ssme_pkg::COUNT_W-1:0] result_count;
	logic                         status;
	logic                         last;

	modport source (output valid, kind, element, result_count, status, last, input ready);
	modport sink (input valid, kind, element, result_count, status, last, output ready);
endinterface

>>> sv/ssme_store.sv
// one set store: single write port, one read port with registered read data
// depends on ssme_pkg for the element width
module ssme_store #(
	parameter int DEPTH = ssme_pkg::SET_DEPTH_DEFAULT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [ssme_pkg::VALUE_W-1:0] wdata,
	input  logic [AW-1:0]                raddr,
	output logic [ssme_pkg::VALUE_W-1:0] rdata
);

	logic [ssme_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [ssme_pkg::VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/ssme_ctrl.sv
// command decode, set lengths and the merge walk over both stores
// depends on ssme_pkg; drives the ports of two ssme_store instances
module ssme_ctrl #(
	parameter int SET_DEPTH = ssme_pkg::SET_DEPTH_DEFAULT,
	parameter int AW        = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1,
	parameter int LW        = $clog2(SET_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [ssme_pkg::FUNC_W-1:0]  cmd_func,
	output logic                         a_we,
	output logic                         b_we,
	output logic [AW-1:0]                a_waddr,
	output logic [AW-1:0]                b_waddr,
	output logic [AW-1:0]                a_raddr,
	output logic [AW-1:0]                b_raddr,
	input  logic [ssme_pkg::VALUE_W-1:0] a_rdata,
	input  logic [ssme_pkg::VALUE_W-1:0] b_rdata,
	input  logic                         can_push,
	output logic                         push,
	output ssme_pkg::result_t            res
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                        state_q;
	logic [ssme_pkg::FUNC_W-1:0]   mode_q;
	logic [LW-1:0]                 a_len_q, b_len_q;
	logic [LW-1:0]                 j_q, k_q;
	logic [ssme_pkg::COUNT_W-1:0]  cnt_q;

	logic          accept, a_full, b_full;
	logic          av, bv, go, take_a, take_b, take_both;
	logic          emit, inc, advance, finish;
	logic [LW-1:0] j_n, k_n;

	assign a_full = (a_len_q == LW'(SET_DEPTH));
	assign b_full = (b_len_q == LW'(SET_DEPTH));

	assign cmd_ready = (state_q == ST_IDLE) && can_push;
	assign accept    = cmd_valid && cmd_ready;

	assign a_we    = accept && (cmd_func == ssme_pkg::FUNC_APPEND_A) && !a_full;
	assign b_we    = accept && (cmd_func == ssme_pkg::FUNC_APPEND_B) && !b_full;
	assign a_waddr = a_len_q[AW-1:0];
	assign b_waddr = b_len_q[AW-1:0];

	// merge compare on the data read for the current indices
	always_comb begin
		av        = j_q < a_len_q;
		bv        = k_q < b_len_q;
		go        = av || ((mode_q != ssme_pkg::FUNC_DIFF) && bv);
		take_a    = av && (!bv || (a_rdata < b_rdata));
		take_b    = !take_a && bv && (!av || (b_rdata < a_rdata));
		take_both = !take_a && !take_b;
		if (take_a) begin
			emit = mode_q != ssme_pkg::FUNC_INTER;
			inc  = mode_q != ssme_pkg::FUNC_INTER;
		end else if (take_b) begin
			emit = mode_q == ssme_pkg::FUNC_UNION;
			inc  = mode_q == ssme_pkg::FUNC_UNION;
		end else begin
			emit = mode_q == ssme_pkg::FUNC_UNION;
			inc  = mode_q != ssme_pkg::FUNC_DIFF;
		end
		advance = (state_q == ST_RUN) && go && (!emit || can_push);
		finish  = (state_q == ST_RUN) && !go && can_push;
		j_n     = j_q + LW'(take_a || take_both);
		k_n     = k_q + LW'(take_b || take_both);
	end

	// look ahead to the next indices so a pair is compared each unstalled cycle
	assign a_raddr = advance ? j_n[AW-1:0] : j_q[AW-1:0];
	assign b_raddr = advance ? k_n[AW-1:0] : k_q[AW-1:0];

	always_comb begin
		push             = 1'b0;
		res.kind         = ssme_pkg::KIND_ACK;
		res.element      = '0;
		res.result_count = '0;
		res.status       = ssme_pkg::STATUS_OK;
		res.last         = 1'b1;
		if (accept) begin
			case (cmd_func) inside
				ssme_pkg::FUNC_UNION, ssme_pkg::FUNC_DIFF, ssme_pkg::FUNC_INTER: begin
					push = 1'b0;
				end
				ssme_pkg::FUNC_APPEND_A: begin
					push       = 1'b1;
					res.status = a_full ? ssme_pkg::STATUS_REFUSED : ssme_pkg::STATUS_OK;
				end
				ssme_pkg::FUNC_APPEND_B: begin
					push       = 1'b1;
					res.status = b_full ? ssme_pkg::STATUS_REFUSED : ssme_pkg::STATUS_OK;
				end
				default: begin
					push = 1'b1;
				end
			endcase
		end else if (advance && emit) begin
			push        = 1'b1;
			res.kind    = ssme_pkg::KIND_ELEM;
			res.element = take_b ? b_rdata : a_rdata;
			res.last    = 1'b0;
		end else if (finish) begin
			push             = 1'b1;
			res.kind         = ssme_pkg::KIND_COUNT;
			res.result_count = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= ssme_pkg::FUNC_CLEAR;
			a_len_q <= '0;
			b_len_q <= '0;
			j_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_func) inside
							ssme_pkg::FUNC_CLEAR: begin
								a_len_q <= '0;
								b_len_q <= '0;
							end
							ssme_pkg::FUNC_APPEND_A: begin
								if (!a_full) a_len_q <= a_len_q + LW'(1);
							end
							ssme_pkg::FUNC_APPEND_B: begin
								if (!b_full) b_len_q <= b_len_q + LW'(1);
							end
							ssme_pkg::FUNC_UNION, ssme_pkg::FUNC_DIFF,
							ssme_pkg::FUNC_INTER: begin
								mode_q  <= cmd_func;
								cnt_q   <= '0;
								state_q <= ST_RUN;
							end
							default: begin
								mode_q <= mode_q;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (advance) begin
						j_q <= j_n;
						k_q <= k_n;
						if (inc) cnt_q <= cnt_q + ssme_pkg::COUNT_W'(1);
					end else if (finish) begin
						// indices return to zero so the idle read address is the first entry
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/sorted_set_merge_engine.sv
// sorted set merge engine: two ascending id sets, union / difference / intersection count
// load items: one per cycle unless held; output register acks the cycle after acceptance
// run items: the item is taken, then one compared pair per cycle while not waiting and the
//   count item, paced by the store read overlapped by reading the next indices ahead
// an emitting step or the count item waits while the output register holds an untaken item
// reset clears the set lengths, the sequencer and the output valid; store contents stay unknown
module sorted_set_merge_engine #(
	parameter int SET_DEPTH = ssme_pkg::SET_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	ssme_cmd_if.sink   cmd,
	ssme_res_if.source res
);

	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int LW = $clog2(SET_DEPTH + 1);

	logic                         a_we, b_we;
	logic [AW-1:0]                a_waddr, b_waddr, a_raddr, b_raddr;
	logic [ssme_pkg::VALUE_W-1:0] a_rdata, b_rdata;
	logic                         can_push, push;
	ssme_pkg::result_t            res_next;
	ssme_pkg::result_t            out_q;
	logic                         out_valid_q;

	ssme_store #(.DEPTH(SET_DEPTH), .AW(AW)) u_store_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (cmd.node_value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	ssme_store #(.DEPTH(SET_DEPTH), .AW(AW)) u_store_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (cmd.node_value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	ssme_ctrl #(.SET_DEPTH(SET_DEPTH), .AW(AW), .LW(LW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.cmd_func  (cmd.func),
		.a_we      (a_we),
		.b_we      (b_we),
		.a_waddr   (a_waddr),
		.b_waddr   (b_waddr),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.a_rdata   (a_rdata),
		.b_rdata   (b_rdata),
		.can_push  (can_push),
		.push      (push),
		.res       (res_next)
	);

	// output register refills in the cycle it is drained
	assign can_push = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push || (out_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res_next;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.kind         = out_q.kind;
	assign res.element      = out_q.element;
	assign res.result_count = out_q.result_count;
	assign res.status       = out_q.status;
	assign res.last         = out_q.last;

endmodule
